FILE: hw/rtl/bitm_pkg.sv
// bitm_pkg: shared widths, codes, entry layout and control structs for the
// box IoU track matcher. No dependencies; used by bitm_scan and the top level.
`default_nettype none

package bitm_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned IDENT_W   = 17;
  localparam int unsigned TEAM_W    = 3;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned OUT_IDX_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  // arithmetic widths
  localparam int unsigned AREA_W  = 2 * COORD_W;      // span * span
  localparam int unsigned UNI_W   = AREA_W + 1;       // union area
  localparam int unsigned CTR_W   = COORD_W + 1;      // doubled centre
  localparam int unsigned DSQ_W   = 2 * CTR_W;        // one squared axis
  localparam int unsigned SQ_W    = DSQ_W + 1;        // squared distance
  localparam int unsigned DEN_LO_W = 17;              // low split of 33-bit operands
  localparam int unsigned DEN_HI_W = UNI_W - DEN_LO_W;
  localparam int unsigned PLO_W   = AREA_W + DEN_LO_W;
  localparam int unsigned PHI_W   = AREA_W + DEN_HI_W;
  localparam int unsigned PROD_W  = AREA_W + UNI_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // match kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OVERLAP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CENTRE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK  = 2'd1;

  localparam logic [CFG_W-1:0]   THRESHOLD_RESET = 16'd6554;
  localparam logic [CFG_W-1:0]   FALLBACK_RESET  = 16'd960;
  localparam logic [UNI_W-1:0]   DEN_INIT        = 33'h0_0001_0000;  // 1.0 in Q0.16
  localparam logic [IDENT_W-1:0] IDENT_NONE      = 17'h1FFFF;

  typedef struct packed {
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_t;

  typedef struct packed {
    box_t               box;
    logic [IDENT_W-1:0] ident;
    logic [TEAM_W-1:0]  team;
  } entry_t;

  typedef struct packed {
    logic ovl_init;   // query setup: load area, limits, best ratio
    logic dst_init;   // start of centre scan: load best squared distance
    logic dst_mode;   // pipeline feeds the centre compare
  } scan_ctrl_t;

  typedef struct packed {
    logic               busy;   // an entry is still in flight
    logic               found;
    logic [KIND_W-1:0]  kind;
    logic [IDENT_W-1:0] ident;
    logic [TEAM_W-1:0]  team;
  } scan_stat_t;

  // extent of lo..hi, zero when inverted or empty
  function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                               input logic [COORD_W-1:0] hi);
    span = (hi > lo) ? hi - lo : '0;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bitm_scan.sv
// bitm_scan: per-entry evaluation pipeline and best-match tracking.
// Overlap ratio by split cross-products, centre distance by squares.
// Depends on bitm_pkg.
`default_nettype none

module bitm_scan #(
  parameter int unsigned IDX_W = 5
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  bitm_pkg::scan_ctrl_t      ctrl,
  input  wire                             rd_valid,
  input  wire  [IDX_W-1:0]                rd_idx,
  input  wire  bitm_pkg::entry_t          rd_entry,
  input  wire  bitm_pkg::box_t            qbox,
  input  wire  [bitm_pkg::CFG_W-1:0]      threshold,
  input  wire  [bitm_pkg::CFG_W-1:0]      fallback,
  output bitm_pkg::scan_stat_t            stat,
  output logic [IDX_W-1:0]                match_idx
);

  // query-wide values
  logic [bitm_pkg::AREA_W-1:0] area_q_r;
  logic [bitm_pkg::DSQ_W-1:0]  fb_sq_r;

  // best so far
  logic [bitm_pkg::AREA_W-1:0]  best_num_r;
  logic [bitm_pkg::UNI_W-1:0]   best_den_r;
  logic [bitm_pkg::SQ_W-1:0]    best_sq_r;
  logic                         found_r;
  logic [bitm_pkg::KIND_W-1:0]  kind_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic [bitm_pkg::IDENT_W-1:0] best_ident_r;
  logic [bitm_pkg::TEAM_W-1:0]  best_team_r;

  // stage valids
  logic v2_r, v3_r, v4_r;

  // entry tag through the stages
  logic [IDX_W-1:0]             idx2_r, idx3_r, idx4_r;
  logic [bitm_pkg::IDENT_W-1:0] ident2_r, ident3_r, ident4_r;
  logic [bitm_pkg::TEAM_W-1:0]  team2_r, team3_r, team4_r;

  // stage 1: spans and products
  logic [bitm_pkg::COORD_W-1:0] ix1, ix2, iy1, iy2;
  logic [bitm_pkg::COORD_W-1:0] iw, ih, ew, eh;
  logic [bitm_pkg::CTR_W-1:0]   qx, qy, ex, ey, dx, dy;
  logic [bitm_pkg::AREA_W-1:0]  inter1, area1;
  logic [bitm_pkg::DSQ_W-1:0]   dxx1, dyy1;
  logic [bitm_pkg::AREA_W-1:0]  inter2_r, area2_r;
  logic [bitm_pkg::DSQ_W-1:0]   dxx2_r, dyy2_r;

  // stage 2: union and squared distance
  logic [bitm_pkg::AREA_W-1:0] inter3_r;
  logic [bitm_pkg::UNI_W-1:0]  uni3_r;
  logic [bitm_pkg::SQ_W-1:0]   sq3_r;

  // stage 3: partial products and centre compare, stage 4: overlap compare
  logic [bitm_pkg::AREA_W-1:0] inter4_r;
  logic [bitm_pkg::UNI_W-1:0]  uni4_r;
  logic [bitm_pkg::PLO_W-1:0]  pa_lo_r, pc_lo_r;
  logic [bitm_pkg::PHI_W-1:0]  pa_hi_r, pc_hi_r;
  logic [bitm_pkg::PROD_W-1:0] lhs, rhs;
  logic                        ovl_take, dst_take;
  logic [bitm_pkg::CTR_W-1:0]  fb2;

  always_comb begin
    ix1 = (qbox.left  > rd_entry.box.left)   ? qbox.left   : rd_entry.box.left;
    iy1 = (qbox.top   > rd_entry.box.top)    ? qbox.top    : rd_entry.box.top;
    ix2 = (qbox.right < rd_entry.box.right)  ? qbox.right  : rd_entry.box.right;
    iy2 = (qbox.bottom < rd_entry.box.bottom) ? qbox.bottom : rd_entry.box.bottom;
    iw  = bitm_pkg::span(ix1, ix2);
    ih  = bitm_pkg::span(iy1, iy2);
    ew  = bitm_pkg::span(rd_entry.box.left, rd_entry.box.right);
    eh  = bitm_pkg::span(rd_entry.box.top, rd_entry.box.bottom);
    inter1 = bitm_pkg::AREA_W'(iw) * bitm_pkg::AREA_W'(ih);
    area1  = bitm_pkg::AREA_W'(ew) * bitm_pkg::AREA_W'(eh);

    qx = {1'b0, qbox.left} + {1'b0, qbox.right};
    qy = {1'b0, qbox.top}  + {1'b0, qbox.bottom};
    ex = {1'b0, rd_entry.box.left} + {1'b0, rd_entry.box.right};
    ey = {1'b0, rd_entry.box.top}  + {1'b0, rd_entry.box.bottom};
    dx = (qx > ex) ? qx - ex : ex - qx;
    dy = (qy > ey) ? qy - ey : ey - qy;
    dxx1 = bitm_pkg::DSQ_W'(dx) * bitm_pkg::DSQ_W'(dx);
    dyy1 = bitm_pkg::DSQ_W'(dy) * bitm_pkg::DSQ_W'(dy);
  end

  // an empty union has zero intersection, so the strict compare rejects it
  assign lhs = bitm_pkg::PROD_W'(pa_lo_r) + {pa_hi_r, {bitm_pkg::DEN_LO_W{1'b0}}};
  assign rhs = bitm_pkg::PROD_W'(pc_lo_r) + {pc_hi_r, {bitm_pkg::DEN_LO_W{1'b0}}};
  assign ovl_take = v4_r && (lhs > rhs);
  assign dst_take = v3_r && ctrl.dst_mode && (sq3_r < best_sq_r);
  assign fb2      = {fallback, 1'b0};

  // datapath registers
  always_ff @(posedge clk) begin
    inter2_r <= inter1;
    area2_r  <= area1;
    dxx2_r   <= dxx1;
    dyy2_r   <= dyy1;
    idx2_r   <= rd_idx;
    ident2_r <= rd_entry.ident;
    team2_r  <= rd_entry.team;

    inter3_r <= inter2_r;
    uni3_r   <= {1'b0, area_q_r} + {1'b0, area2_r} - {1'b0, inter2_r};
    sq3_r    <= {1'b0, dxx2_r} + {1'b0, dyy2_r};
    idx3_r   <= idx2_r;
    ident3_r <= ident2_r;
    team3_r  <= team2_r;

    pa_lo_r  <= bitm_pkg::PLO_W'(inter3_r) *
                bitm_pkg::PLO_W'(best_den_r[bitm_pkg::DEN_LO_W-1:0]);
    pa_hi_r  <= bitm_pkg::PHI_W'(inter3_r) *
                bitm_pkg::PHI_W'(best_den_r[bitm_pkg::UNI_W-1:bitm_pkg::DEN_LO_W]);
    pc_lo_r  <= bitm_pkg::PLO_W'(best_num_r) *
                bitm_pkg::PLO_W'(uni3_r[bitm_pkg::DEN_LO_W-1:0]);
    pc_hi_r  <= bitm_pkg::PHI_W'(best_num_r) *
                bitm_pkg::PHI_W'(uni3_r[bitm_pkg::UNI_W-1:bitm_pkg::DEN_LO_W]);
    inter4_r <= inter3_r;
    uni4_r   <= uni3_r;
    idx4_r   <= idx3_r;
    ident4_r <= ident3_r;
    team4_r  <= team3_r;

    if (ctrl.ovl_init) begin
      area_q_r <= bitm_pkg::AREA_W'(bitm_pkg::span(qbox.left, qbox.right)) *
                  bitm_pkg::AREA_W'(bitm_pkg::span(qbox.top, qbox.bottom));
      fb_sq_r  <= bitm_pkg::DSQ_W'(fb2) * bitm_pkg::DSQ_W'(fb2);
    end
  end

  // valids and best match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v2_r <= rd_valid;
      v3_r <= v2_r;
      v4_r <= v3_r && !ctrl.dst_mode;

      if (ctrl.ovl_init) begin
        best_num_r <= bitm_pkg::AREA_W'(threshold);
        best_den_r <= bitm_pkg::DEN_INIT;
        found_r    <= 1'b0;
      end else if (ctrl.dst_init) begin
        best_sq_r <= bitm_pkg::SQ_W'(fb_sq_r);
      end else if (ovl_take) begin
        best_num_r   <= inter4_r;
        best_den_r   <= uni4_r;
        found_r      <= 1'b1;
        kind_r       <= bitm_pkg::KIND_OVERLAP;
        best_idx_r   <= idx4_r;
        best_ident_r <= ident4_r;
        best_team_r  <= team4_r;
      end else if (dst_take) begin
        best_sq_r    <= sq3_r;
        found_r      <= 1'b1;
        kind_r       <= bitm_pkg::KIND_CENTRE;
        best_idx_r   <= idx3_r;
        best_ident_r <= ident3_r;
        best_team_r  <= team3_r;
      end
    end
  end

  always_comb begin
    stat.busy  = v2_r || v3_r || v4_r;
    stat.found = found_r;
    stat.kind  = kind_r;
    stat.ident = best_ident_r;
    stat.team  = best_team_r;
  end
  assign match_idx = best_idx_r;

endmodule

`default_nettype wire

FILE: hw/rtl/box_iou_track_matcher_top.sv
// box_iou_track_matcher_top: box table, scan sequencer, config and result registers.
// Depends on bitm_pkg and bitm_scan.
// Clear/add: done in the accept cycle. Query: an overlap scan of every held entry, then a
// centre scan if no overlap matched. The overlap scan reads only while its phase bit is low
// (best-ratio feedback), the centre scan every cycle. Result beat in the cycle busy drops,
// never stalled. Sync active-low reset empties the table and restores the registers.
`default_nettype none

module box_iou_track_matcher_top #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // command channel
  input  wire                                start,
  output logic                               busy,
  input  wire  [bitm_pkg::ACT_W-1:0]         in_action,
  input  wire  [bitm_pkg::COORD_W-1:0]       in_box_left,
  input  wire  [bitm_pkg::COORD_W-1:0]       in_box_top,
  input  wire  [bitm_pkg::COORD_W-1:0]       in_box_right,
  input  wire  [bitm_pkg::COORD_W-1:0]       in_box_bottom,
  input  wire  signed [bitm_pkg::IDENT_W-1:0] in_ident,
  input  wire  [bitm_pkg::TEAM_W-1:0]        in_team_code,
  // result channel
  output logic                               out_strobe,
  output logic [bitm_pkg::KIND_W-1:0]        out_match_kind,
  output logic [bitm_pkg::OUT_IDX_W-1:0]     out_entry_index,
  output logic signed [bitm_pkg::IDENT_W-1:0] out_matched_ident,
  output logic [bitm_pkg::TEAM_W-1:0]        out_matched_team,
  // configuration
  input  wire                                cfg_we,
  input  wire  [bitm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [bitm_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_OVL   = 4'b0100,
    ST_DST   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]            count_r;     // held entries
  logic [CNT_W-1:0]            rd_ptr_r;    // entries issued in this scan
  logic                        phase_r;     // toggles during the overlap scan, which issues only while it is low
  logic                        rd_valid_r;
  logic [IDX_W-1:0]            rd_idx_r;
  bitm_pkg::entry_t            rd_entry_r;
  bitm_pkg::box_t              qbox_r;
  logic [bitm_pkg::CFG_W-1:0]  threshold_r;
  logic [bitm_pkg::CFG_W-1:0]  fallback_r;

  logic                         out_strobe_r;
  logic [bitm_pkg::KIND_W-1:0]  out_kind_r;
  logic [bitm_pkg::OUT_IDX_W-1:0] out_idx_r;
  logic [bitm_pkg::IDENT_W-1:0] out_ident_r;
  logic [bitm_pkg::TEAM_W-1:0]  out_team_r;

  // table: one synchronous memory, one write and one registered read port
  bitm_pkg::entry_t entry_mem [MAX_ENTRIES];

  logic                 in_accept;
  logic                 mem_we;
  bitm_pkg::entry_t     wr_entry;
  logic                 issue;
  logic                 scan_done;
  logic                 finish;
  bitm_pkg::scan_ctrl_t ctrl;
  bitm_pkg::scan_stat_t stat;
  logic [IDX_W-1:0]     match_idx;
  logic [IDX_W+bitm_pkg::OUT_IDX_W-1:0] idx_ext;

  assign in_accept = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);

  // adds are taken only while idle, so a write never meets a scan read
  assign mem_we = in_accept && (in_action == bitm_pkg::ACT_ADD) &&
                  (count_r < CNT_W'(MAX_ENTRIES));

  always_comb begin
    wr_entry.box.left   = in_box_left;
    wr_entry.box.top    = in_box_top;
    wr_entry.box.right  = in_box_right;
    wr_entry.box.bottom = in_box_bottom;
    wr_entry.ident      = $unsigned(in_ident);
    wr_entry.team       = in_team_code;
  end

  // scan sequencing
  assign issue = (rd_ptr_r != count_r) &&
                 (((state_r == ST_OVL) && !phase_r) || (state_r == ST_DST));
  // all entries read and the pipeline drained
  assign scan_done = (rd_ptr_r == count_r) && !rd_valid_r && !stat.busy;

  always_comb begin
    ctrl.ovl_init = (state_r == ST_SETUP);
    ctrl.dst_mode = (state_r == ST_DST);
    ctrl.dst_init = (state_r == ST_OVL) && scan_done && !stat.found;
  end

  assign finish = scan_done &&
                  (((state_r == ST_OVL) && stat.found) || (state_r == ST_DST));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_action == bitm_pkg::ACT_QUERY)) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_OVL;
      ST_OVL: begin
        if (scan_done) state_nxt = stat.found ? ST_IDLE : ST_DST;
      end
      ST_DST: begin
        if (scan_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    if (issue) begin
      rd_entry_r <= entry_mem[rd_ptr_r[IDX_W-1:0]];
      rd_idx_r   <= rd_ptr_r[IDX_W-1:0];
    end
  end

  // control, query box, config and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rd_ptr_r     <= '0;
      phase_r      <= 1'b0;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      threshold_r  <= bitm_pkg::THRESHOLD_RESET;
      fallback_r   <= bitm_pkg::FALLBACK_RESET;
    end else begin
      state_r      <= state_nxt;
      rd_valid_r   <= issue;
      out_strobe_r <= finish;

      if (in_accept) begin
        case (in_action)
          bitm_pkg::ACT_CLEAR: count_r <= '0;
          bitm_pkg::ACT_ADD: begin
            if (mem_we) count_r <= count_r + 1'b1;
          end
          bitm_pkg::ACT_QUERY: begin
            qbox_r   <= wr_entry.box;
            rd_ptr_r <= '0;
            phase_r  <= 1'b0;
          end
          default: ;  // unused action: no effect
        endcase
      end

      if (issue) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (state_r == ST_OVL) phase_r <= !phase_r;
      if (ctrl.dst_init) rd_ptr_r <= '0;

      if (finish) begin
        if (stat.found) begin
          out_kind_r  <= stat.kind;
          out_idx_r   <= idx_ext[bitm_pkg::OUT_IDX_W-1:0];
          out_ident_r <= stat.ident;
          out_team_r  <= stat.team;
        end else begin
          out_kind_r  <= bitm_pkg::KIND_NONE;
          out_idx_r   <= '0;
          out_ident_r <= bitm_pkg::IDENT_NONE;
          out_team_r  <= '0;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          bitm_pkg::REG_THRESHOLD: threshold_r <= cfg_wdata;
          bitm_pkg::REG_FALLBACK:  fallback_r  <= cfg_wdata;
          default: ;  // unknown register: ignored
        endcase
      end
    end
  end

  // entry index keeps its low five bits whatever the table depth
  assign idx_ext = {{bitm_pkg::OUT_IDX_W{1'b0}}, match_idx};

  bitm_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .rd_valid  (rd_valid_r),
    .rd_idx    (rd_idx_r),
    .rd_entry  (rd_entry_r),
    .qbox      (qbox_r),
    .threshold (threshold_r),
    .fallback  (fallback_r),
    .stat      (stat),
    .match_idx (match_idx)
  );

  assign out_strobe        = out_strobe_r;
  assign out_match_kind    = out_kind_r;
  assign out_entry_index   = out_idx_r;
  assign out_matched_ident = $signed(out_ident_r);
  assign out_matched_team  = out_team_r;

endmodule

`default_nettype wire

FILE: sim/tb_box_iou_track_matcher_top.sv
// Self-checking testbench for box_iou_track_matcher_top: directed table, then random
// clear/add/query sequences under several register settings, scored by an in-bench predictor.
// Depends on bitm_pkg and the box_iou_track_matcher_top RTL; nothing else.
`timescale 1ns / 100ps

module tb_box_iou_track_matcher_top;
  import bitm_pkg::*;

  localparam int ENTRIES          = 32;
  localparam int QUERY_MAX_CYCLES = 3 * ENTRIES + 10;   // no-overlap query on a full table
  localparam int TAIL_CYCLES      = QUERY_MAX_CYCLES + 16;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int PHASE_COUNT      = 7;
  localparam int PHASE_ITEMS      = 250;

  // codes the package does not name
  localparam logic [ACT_W-1:0]     ACT_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // box generator styles
  localparam int BOX_WIDE    = 0;   // any coordinates at all
  localparam int BOX_REGION  = 1;   // sane box in a crowded corner of the frame
  localparam int BOX_NEAR    = 2;   // nudged copy of a held entry
  localparam int BOX_INVERT  = 3;   // right <= left, and sometimes bottom < top as well
  localparam int BOX_EXTREME = 4;   // coordinates pinned at 0 or full scale, or random

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    box_t               box;
    logic [IDENT_W-1:0] ident;
    logic [TEAM_W-1:0]  team;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [OUT_IDX_W-1:0] index;
    logic [IDENT_W-1:0]   ident;
    logic [TEAM_W-1:0]    team;
  } match_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   typed;   // expectation typed into the table, not predicted
    match_t want;
  } dir_row_t;

  localparam match_t NO_MATCH = '{KIND_NONE, 5'd0, IDENT_NONE, 3'd0};

  // ------------------------------------------------------------------
  // clock, reset, DUT
  // ------------------------------------------------------------------
  logic clk = 1'b0;
  always #1 clk = ~clk;

  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [ACT_W-1:0]           in_action;
  logic [COORD_W-1:0]         in_box_left, in_box_top, in_box_right, in_box_bottom;
  logic signed [IDENT_W-1:0]  in_ident;
  logic [TEAM_W-1:0]          in_team_code;
  logic                       out_strobe;
  logic [KIND_W-1:0]          out_match_kind;
  logic [OUT_IDX_W-1:0]       out_entry_index;
  logic signed [IDENT_W-1:0]  out_matched_ident;
  logic [TEAM_W-1:0]          out_matched_team;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;

  box_iou_track_matcher_top #(.MAX_ENTRIES(ENTRIES)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_box_left       (in_box_left),
    .in_box_top        (in_box_top),
    .in_box_right      (in_box_right),
    .in_box_bottom     (in_box_bottom),
    .in_ident          (in_ident),
    .in_team_code      (in_team_code),
    .out_strobe        (out_strobe),
    .out_match_kind    (out_match_kind),
    .out_entry_index   (out_entry_index),
    .out_matched_ident (out_matched_ident),
    .out_matched_team  (out_matched_team),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // ------------------------------------------------------------------
  // shadow of the reference table and the two registers
  // ------------------------------------------------------------------
  box_t               track_box   [ENTRIES];
  logic [IDENT_W-1:0] track_ident [ENTRIES];
  logic [TEAM_W-1:0]  track_team  [ENTRIES];
  int                 track_count;
  logic [CFG_W-1:0]   iou_limit;      // Q0.16
  logic [CFG_W-1:0]   centre_limit;   // Q16.0

  match_t   pending_matches [$];   // one per accepted query, oldest first
  dir_row_t directed_rows [$];
  int       errors = 0;
  bit       gaps_on = 1'b1;

  // extent of lo..hi, zero when the span is empty or inverted
  function automatic logic [COORD_W-1:0] extent(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  // Best match for a detection box against the shadow table.
  // IoU ratios are compared as cross-products so no division is needed;
  // the centre pass works on doubled centres against (2 * limit)^2.
  function automatic match_t predict_match(input box_t q);
    match_t             res;
    logic [97:0]        area_q, area_e, inter, uni, best_num, best_den;
    logic [63:0]        qx, qy, ex, ey, dx, dy, sq, best_sq;
    logic [COORD_W-1:0] ix1, iy1, ix2, iy2;
    box_t               e;
    bit                 found;
    int                 hit;
    found    = 1'b0;
    hit      = 0;
    res      = NO_MATCH;
    area_q   = 98'(extent(q.left, q.right)) * 98'(extent(q.top, q.bottom));
    best_num = 98'(iou_limit);
    best_den = 98'd65536;
    for (int i = 0; i < track_count; i++) begin
      e      = track_box[i];
      ix1    = (q.left > e.left) ? q.left : e.left;
      iy1    = (q.top > e.top) ? q.top : e.top;
      ix2    = (q.right < e.right) ? q.right : e.right;
      iy2    = (q.bottom < e.bottom) ? q.bottom : e.bottom;
      inter  = 98'(extent(ix1, ix2)) * 98'(extent(iy1, iy2));
      area_e = 98'(extent(e.left, e.right)) * 98'(extent(e.top, e.bottom));
      uni    = area_q + area_e - inter;
      // an empty union counts as IoU 0 and can never pass
      if (uni != '0 && inter * best_den > best_num * uni) begin
        best_num = inter;
        best_den = uni;
        hit      = i;
        found    = 1'b1;
        res.kind = KIND_OVERLAP;
      end
    end
    if (!found) begin
      best_sq = 64'd4 * 64'(centre_limit) * 64'(centre_limit);
      qx      = 64'(q.left) + 64'(q.right);
      qy      = 64'(q.top) + 64'(q.bottom);
      for (int i = 0; i < track_count; i++) begin
        e  = track_box[i];
        ex = 64'(e.left) + 64'(e.right);
        ey = 64'(e.top) + 64'(e.bottom);
        dx = (qx > ex) ? qx - ex : ex - qx;
        dy = (qy > ey) ? qy - ey : ey - qy;
        sq = dx * dx + dy * dy;
        if (sq < best_sq) begin
          best_sq  = sq;
          hit      = i;
          found    = 1'b1;
          res.kind = KIND_CENTRE;
        end
      end
    end
    if (found) begin
      res.index = 5'(hit);
      res.ident = track_ident[hit];
      res.team  = track_team[hit];
    end
    return res;
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  function automatic cmd_t mk_cmd(input logic [ACT_W-1:0] act,
                                  input logic [COORD_W-1:0] l, t, r, b,
                                  input logic [IDENT_W-1:0] id,
                                  input logic [TEAM_W-1:0] tm);
    cmd_t c;
    c.action     = act;
    c.box.left   = l;
    c.box.top    = t;
    c.box.right  = r;
    c.box.bottom = b;
    c.ident      = id;
    c.team       = tm;
    return c;
  endfunction

  // append one row to the directed table
  task automatic add_row(input cmd_t c, input logic typed, input match_t want);
    dir_row_t row;
    row.cmd   = c;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] v, input int s);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * s)) - s;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return 16'(t);
  endfunction

  function automatic logic [COORD_W-1:0] pinned();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic box_t rand_box(input int style);
    box_t               b;
    logic [COORD_W-1:0] x, y, swap;
    int                 s;
    int                 j;
    x = 16'($urandom_range(0, 6000));
    y = 16'($urandom_range(0, 6000));
    b.left   = x;
    b.top    = y;
    b.right  = x + 16'($urandom_range(1, 2500));
    b.bottom = y + 16'($urandom_range(1, 2500));
    case (style)
      BOX_WIDE: begin
        b.left   = 16'($urandom_range(0, 65535));
        b.top    = 16'($urandom_range(0, 65535));
        b.right  = 16'($urandom_range(0, 65535));
        b.bottom = 16'($urandom_range(0, 65535));
      end
      BOX_NEAR: begin
        if (track_count > 0) begin
          j = $urandom_range(0, track_count - 1);
          case ($urandom_range(0, 5))
            0:       s = 0;                          // exact copy, IoU of one
            1, 2:    s = $urandom_range(1, 200);
            default: s = $urandom_range(200, 2000);  // mostly a centre-distance case
          endcase
          b.left   = nudge(track_box[j].left, s);
          b.top    = nudge(track_box[j].top, s);
          b.right  = nudge(track_box[j].right, s);
          b.bottom = nudge(track_box[j].bottom, s);
        end
      end
      BOX_INVERT: begin
        if ($urandom_range(0, 1) == 0) begin
          swap = b.left; b.left = b.right; b.right = swap;
        end else begin
          b.right = b.left;
        end
        if ($urandom_range(0, 1) == 0) begin
          swap = b.top; b.top = b.bottom; b.bottom = swap;
        end
      end
      BOX_EXTREME: begin
        b.left   = pinned();
        b.top    = pinned();
        b.right  = pinned();
        b.bottom = pinned();
      end
      default: ;
    endcase
    return b;
  endfunction

  function automatic cmd_t rand_cmd(input logic [ACT_W-1:0] act, input int style);
    cmd_t c;
    c.action = act;
    c.box    = rand_box(style);
    c.ident  = ($urandom_range(0, 7) == 0) ? IDENT_NONE : 17'($urandom_range(0, 65535));
    c.team   = 3'($urandom_range(0, 7));
    return c;
  endfunction

  // Present one beat and hold it until the block takes it. The shadow is
  // updated, and a query's expectation queued, at the accepting edge.
  task automatic issue(input cmd_t c, input logic typed, input match_t want);
    bit taken;
    taken = 1'b0;
    if (gaps_on && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(4, 60)) @(negedge clk);
      else repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start         <= 1'b1;
    in_action     <= c.action;
    in_box_left   <= c.box.left;
    in_box_top    <= c.box.top;
    in_box_right  <= c.box.right;
    in_box_bottom <= c.box.bottom;
    in_ident      <= c.ident;
    in_team_code  <= c.team;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1'b1;
        case (c.action)
          ACT_CLEAR: track_count = 0;
          ACT_ADD: begin
            // a full table drops the add
            if (track_count < ENTRIES) begin
              track_box[track_count]   = c.box;
              track_ident[track_count] = c.ident;
              track_team[track_count]  = c.team;
              track_count++;
            end
          end
          ACT_QUERY: pending_matches.insert(pending_matches.size(),
                                            typed ? want : predict_match(c.box));
          default: ;   // unused action: no effect, no result
        endcase
      end
      @(negedge clk);
    end
  endtask

  // Hold the sender off until every result is in and the block is idle.
  task automatic settle();
    start <= 1'b0;
    while (pending_matches.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_THRESHOLD: iou_limit = val;
      REG_FALLBACK:  centre_limit = val;
      default: ;   // unknown index, ignored
    endcase
  endtask

  // Well-formed runs of clear, adds, queries with random content; now and
  // then the clear is skipped (table carries over) or a stray beat slips in.
  task automatic random_phase(input int n_items);
    int done;
    int n_add;
    int style;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 9) != 0) begin
        issue(rand_cmd(ACT_CLEAR, BOX_WIDE), 1'b0, '0);
        done++;
      end
      case ($urandom_range(0, 19))
        0, 1, 2:    n_add = $urandom_range(28, 36);   // may fill the table and drop some
        3, 4, 5, 6: n_add = $urandom_range(7, 20);
        default:    n_add = $urandom_range(0, 6);
      endcase
      repeat (n_add) begin
        if ($urandom_range(0, 19) == 0) issue(rand_cmd(ACT_UNUSED, BOX_WIDE), 1'b0, '0);
        case ($urandom_range(0, 9))
          0:       style = BOX_WIDE;
          1:       style = BOX_INVERT;
          2:       style = BOX_EXTREME;
          3:       style = BOX_NEAR;
          default: style = BOX_REGION;
        endcase
        issue(rand_cmd(ACT_ADD, style), 1'b0, '0);
        done++;
      end
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 19))
          0, 1:          style = BOX_WIDE;
          2, 3:          style = BOX_INVERT;
          4, 5:          style = BOX_EXTREME;
          6, 7, 8, 9, 10: style = BOX_REGION;
          default:       style = BOX_NEAR;
        endcase
        issue(rand_cmd(ACT_QUERY, style), 1'b0, '0);
        done++;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // result checker: every strobe beat against the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_strobe) begin
      if (pending_matches.size() == 0) begin
        $error("result beat with no query outstanding");
        errors++;
      end else begin
        want = pending_matches.pop_front();
        if (out_match_kind !== want.kind) begin
          $error("match_kind: expected %0d, got %0d", want.kind, out_match_kind);
          errors++;
        end
        if (out_entry_index !== want.index) begin
          $error("entry_index: expected %0d, got %0d", want.index, out_entry_index);
          errors++;
        end
        if (out_matched_ident !== want.ident) begin
          $error("matched_ident: expected %0h, got %0h", want.ident, out_matched_ident);
          errors++;
        end
        if (out_matched_team !== want.team) begin
          $error("matched_team: expected %0d, got %0d", want.team, out_matched_team);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_box_iou_track_matcher_top NOT OK");
    $finish;
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_action     <= ACT_CLEAR;
    in_box_left   <= '0;
    in_box_top    <= '0;
    in_box_right  <= '0;
    in_box_bottom <= '0;
    in_ident      <= '0;
    in_team_code  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_THRESHOLD;
    cfg_wdata     <= '0;
    track_count   = 0;
    iou_limit     = THRESHOLD_RESET;
    centre_limit  = FALLBACK_RESET;

    // Directed table. Expectations typed in only where obvious; the rest
    // go through the predictor.
    // empty table straight after reset
    add_row(mk_cmd(ACT_QUERY, 100, 100, 200, 200, 0, 0), 1'b1, NO_MATCH);
    // unused action with every field bit set: no result
    add_row(mk_cmd(ACT_UNUSED, '1, '1, '1, '1, '1, '1), 1'b0, '0);
    // zero-area box at the origin, no track id
    add_row(mk_cmd(ACT_ADD, 0, 0, 0, 0, IDENT_NONE, 0), 1'b0, '0);
    add_row(mk_cmd(ACT_ADD, 100, 100, 200, 200, 0, 1), 1'b0, '0);
    // full-frame box, id 65535 and largest team
    add_row(mk_cmd(ACT_ADD, 0, 0, '1, '1, 17'd65535, 7), 1'b0, '0);
    // inverted box, area zero
    add_row(mk_cmd(ACT_ADD, 300, 300, 250, 250, 17'd12345, 4), 1'b0, '0);
    add_row(mk_cmd(ACT_QUERY, 100, 100, 200, 200, 0, 0), 1'b0, '0);
    // point at the origin: every union empty or IoU zero, centre hit on entry 0
    add_row(mk_cmd(ACT_QUERY, 0, 0, 0, 0, 0, 0), 1'b1,
            match_t'{KIND_CENTRE, 5'd0, IDENT_NONE, 3'd0});
    add_row(mk_cmd(ACT_QUERY, '1, '1, '1, '1, 0, 0), 1'b0, '0);
    add_row(mk_cmd(ACT_QUERY, 0, 0, '1, '1, 0, 0), 1'b0, '0);
    add_row(mk_cmd(ACT_QUERY, 300, 300, 250, 250, 0, 0), 1'b0, '0);
    add_row(mk_cmd(ACT_QUERY, 1000, 1000, 1100, 1100, 0, 0), 1'b0, '0);
    add_row(mk_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_cmd(ACT_QUERY, 0, 0, '1, '1, '1, '1), 1'b1, NO_MATCH);
    // full-scale point: union empty, exact centre hit
    add_row(mk_cmd(ACT_ADD, '1, '1, '1, '1, 17'd1, 2), 1'b0, '0);
    add_row(mk_cmd(ACT_QUERY, '1, '1, '1, '1, 0, 0), 1'b1,
            match_t'{KIND_CENTRE, 5'd0, 17'd1, 3'd2});
    add_row(mk_cmd(ACT_ADD, 0, 0, 1, 1, 17'd65535, 7), 1'b0, '0);
    add_row(mk_cmd(ACT_QUERY, 0, 0, 1, 1, 0, 0), 1'b1,
            match_t'{KIND_OVERLAP, 5'd1, 17'd65535, 3'd7});
    add_row(mk_cmd(ACT_UNUSED, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_cmd(ACT_CLEAR, '1, '1, '1, '1, '1, '1), 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // Random phases, one register setting each; writes only once the block
    // has drained. Phase 2 runs with no sender gaps at all.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      gaps_on = (p != 2);
      case (p)
        0: begin
          write_reg(REG_THRESHOLD, '0);
          write_reg(REG_FALLBACK, '0);
        end
        1: begin
          write_reg(REG_THRESHOLD, '1);
          write_reg(REG_FALLBACK, '1);
        end
        3: begin
          // back to reset values, then make sure the spare indexes alias nothing
          write_reg(REG_THRESHOLD, THRESHOLD_RESET);
          write_reg(REG_FALLBACK, FALLBACK_RESET);
          write_reg(REG_SPARE_A, '1);
          write_reg(REG_SPARE_B, '0);
        end
        4: begin
          write_reg(REG_THRESHOLD, 16'($urandom_range(0, 16000)));
          write_reg(REG_FALLBACK, 16'($urandom_range(0, 3000)));
        end
        default: begin
          write_reg(REG_THRESHOLD, 16'($urandom_range(0, 65535)));
          write_reg(REG_FALLBACK, 16'($urandom_range(0, 65535)));
        end
      endcase
      random_phase(PHASE_ITEMS);
    end

    start <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) $display("tb_box_iou_track_matcher_top OK");
    else $display("tb_box_iou_track_matcher_top NOT OK");
    $finish;
  end

endmodule

FILE: box_iou_track_matcher_top.f
hw/rtl/bitm_pkg.sv
hw/rtl/bitm_scan.sv
hw/rtl/box_iou_track_matcher_top.sv
sim/tb_box_iou_track_matcher_top.sv
